/* rtl/gpio_set_clear_register_bank_assert.svh */
// Assertion macros shared by the register bank RTL.
`ifndef GPIO_SET_CLEAR_REGISTER_BANK_ASSERT_SVH
`define GPIO_SET_CLEAR_REGISTER_BANK_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GSC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/gpio_sc_pkg.sv */
package gpio_sc_pkg;

  localparam int unsigned DEFAULT_PIN_COUNT = 256;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned OFFSET_W = 11;

  localparam int unsigned BANK_DEPTH = 8;
  localparam int unsigned MODE_DEPTH = 32;
  localparam int unsigned BANK_W = $clog2(BANK_DEPTH);
  localparam int unsigned MODE_W = $clog2(MODE_DEPTH);
  localparam int unsigned WORD_DEPTH = 2 * BANK_DEPTH + MODE_DEPTH;
  localparam int unsigned ADDR_W = $clog2(WORD_DEPTH);

  localparam logic [OFFSET_W-1:0] DIR_BASE = 11'h000;
  localparam logic [OFFSET_W-1:0] OUT_BASE = 11'h100;
  localparam logic [OFFSET_W-1:0] IN_BASE = 11'h200;
  localparam logic [OFFSET_W-1:0] MODE_BASE = 11'h300;
  localparam logic [OFFSET_W-1:0] MODE_END = 11'h500;

  localparam logic [3:0] SLOT_VAL = 4'h0;
  localparam logic [3:0] SLOT_SET = 4'h4;
  localparam logic [3:0] SLOT_CLR = 4'h8;

  localparam logic FUNC_READ = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  typedef struct packed {
    logic func;
    logic [OFFSET_W-1:0] offset;
    logic [WORD_W-1:0] write_data;
    logic [WORD_W-1:0] pad_levels;
  } req_t;

  typedef struct packed {
    logic [WORD_W-1:0] read_data;
    logic bad_offset;
  } rsp_t;

  typedef enum logic [1:0] {
    KIND_DIR  = 2'd0,
    KIND_OUT  = 2'd1,
    KIND_IN   = 2'd2,
    KIND_MODE = 2'd3
  } kind_e;

  typedef struct packed {
    logic bad;
    kind_e kind;
    logic [ADDR_W-1:0] addr;
    logic [3:0] slot;
    logic [WORD_W-1:0] mask;
  } decode_t;

  // Bits that belong to existing pins when each pin takes bits_per_pin bits.
  function automatic logic [WORD_W-1:0] live_mask(input int unsigned first_pin,
                                                  input int unsigned pins,
                                                  input int unsigned bits_per_pin,
                                                  input int unsigned pin_count);
    int unsigned n;
    logic [WORD_W-1:0] m;
    n = 0;
    if (first_pin >= pin_count) begin
      m = '0;
    end else begin
      n = pin_count - first_pin;
      if (n >= pins) begin
        m = '1;
      end else begin
        n = n * bits_per_pin;
        if (n >= WORD_W) m = '1;
        else m = WORD_W'((64'd1 << n) - 64'd1);
      end
    end
    return m;
  endfunction

endpackage

/* rtl/gpio_set_clear_register_bank.sv */
// GPIO register bank with VAL/SET/CLR triples. Each request transaction is one
// 32-bit bus access; each produces exactly one response transaction carrying the
// word read (zero for writes and unmapped offsets) and a bad-offset flag. All
// direction, output-level and mode words live in one 48-word synchronous RAM,
// and each access is a read-modify-write of a single word: the RAM is read at
// the edge that accepts the request and written back at the edge that ends the
// lookup state, the same edge that loads the response register. The block
// takes no new request until the previous access has finished. A new
// request is accepted while the previous response still waits in the output
// register; the access then holds in its lookup state until that
// register frees. Per-word valid flops, cleared by reset, make every word read
// as zero until first written, so no clearing pass is needed after reset.
// Bits of pins beyond PIN_COUNT are always stored and returned as zero.
`include "gpio_set_clear_register_bank_assert.svh"

module gpio_set_clear_register_bank #(
  parameter int unsigned PIN_COUNT = gpio_sc_pkg::DEFAULT_PIN_COUNT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  gpio_sc_pkg::req_t  req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output gpio_sc_pkg::rsp_t  rsp
);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_LOOKUP = 2'b10
  } state_t;

  state_t state, state_next;

  gpio_sc_pkg::decode_t dec;
  gpio_sc_pkg::decode_t dec_q;
  gpio_sc_pkg::req_t    req_q;

  logic [gpio_sc_pkg::WORD_W-1:0] mem [gpio_sc_pkg::WORD_DEPTH];
  logic [gpio_sc_pkg::WORD_W-1:0] rd_word;
  logic [gpio_sc_pkg::WORD_DEPTH-1:0] word_valid;

  logic accept;
  logic finish;
  logic mem_we;
  logic [gpio_sc_pkg::WORD_W-1:0] old_word;
  logic [gpio_sc_pkg::WORD_W-1:0] new_word;
  logic [gpio_sc_pkg::WORD_W-1:0] rd_result;

  gpio_sc_decode #(
    .PIN_COUNT(PIN_COUNT)
  ) u_decode (
    .offset(req.offset),
    .dec   (dec)
  );

  assign req_ready = (state == ST_IDLE);
  assign accept = req_valid && req_ready;
  // The lookup state completes once the output register is free or emptying.
  assign finish = (state == ST_LOOKUP) && (!rsp_valid || rsp_ready);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (accept) state_next = ST_LOOKUP;
      ST_LOOKUP: if (finish) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Request and its decode are held for the write-back cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
      dec_q <= dec;
    end
  end

  // Word store: read at acceptance, written back when the access finishes.
  // Accesses never overlap, so no forwarding is required.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[dec_q.addr] <= new_word;
    end
    if (accept) begin
      rd_word <= mem[dec.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= '0;
    end else if (mem_we) begin
      word_valid[dec_q.addr] <= 1'b1;
    end
  end

  assign old_word = word_valid[dec_q.addr] ? rd_word : '0;

  always_comb begin
    case (dec_q.slot)
      gpio_sc_pkg::SLOT_SET: new_word = (old_word | req_q.write_data) & dec_q.mask;
      gpio_sc_pkg::SLOT_CLR: new_word = (old_word & ~req_q.write_data) & dec_q.mask;
      default:               new_word = req_q.write_data & dec_q.mask;
    endcase
  end

  // Writes to the input-level region are accepted and dropped.
  assign mem_we = finish && !dec_q.bad && (req_q.func == gpio_sc_pkg::FUNC_WRITE)
                && (dec_q.kind != gpio_sc_pkg::KIND_IN);

  always_comb begin
    if (dec_q.bad || req_q.func == gpio_sc_pkg::FUNC_WRITE) begin
      rd_result = '0;
    end else if (dec_q.kind == gpio_sc_pkg::KIND_IN) begin
      rd_result = req_q.pad_levels & dec_q.mask;
    end else begin
      rd_result = old_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (finish) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      rsp.read_data <= rd_result;
      rsp.bad_offset <= dec_q.bad;
    end
  end

  `GSC_ASSERT_NEXT(a_accept_enters_lookup, clk, rst, accept, state == ST_LOOKUP,
                   "accepted request did not move to the lookup cycle")
  `GSC_ASSERT_NEXT(a_stall_holds_lookup, clk, rst,
                   state == ST_LOOKUP && rsp_valid && !rsp_ready,
                   state == ST_LOOKUP && $stable(rsp),
                   "lookup finished while the response register was still full")
  `GSC_ASSERT_NOW(a_bad_reads_zero, clk, rst, rsp_valid && rsp.bad_offset,
                  rsp.read_data == '0, "unmapped access returned nonzero data")
  `GSC_ASSERT_NOW(a_write_only_on_finish, clk, rst, mem_we,
                  state == ST_LOOKUP && !accept,
                  "word store written outside the write-back cycle")

endmodule

/* rtl/gpio_sc_decode.sv */
module gpio_sc_decode #(
  parameter int unsigned PIN_COUNT = gpio_sc_pkg::DEFAULT_PIN_COUNT
) (
  input  logic [gpio_sc_pkg::OFFSET_W-1:0] offset,
  output gpio_sc_pkg::decode_t             dec
);

  logic [3:0] slot;
  logic [3:0] bank;
  logic [gpio_sc_pkg::MODE_W-1:0] mode_idx;

  assign slot = offset[3:0];
  assign bank = offset[7:4];
  // Mode words run from 0x300 to 0x4FF, so bit 10 tells the upper half.
  assign mode_idx = {offset[10], offset[7:4]};

  always_comb begin
    dec = '0;
    dec.bad = 1'b1;
    dec.kind = gpio_sc_pkg::KIND_DIR;
    dec.slot = slot;
    if (offset[1:0] == 2'b00 && slot <= gpio_sc_pkg::SLOT_CLR) begin
      if (offset < gpio_sc_pkg::MODE_BASE) begin
        if (32'(bank) < gpio_sc_pkg::BANK_DEPTH) begin
          dec.mask = gpio_sc_pkg::live_mask(32'(bank) * 32, 32, 1, PIN_COUNT);
        end
        dec.bad = (dec.mask == '0);
        if (offset[10:8] == gpio_sc_pkg::DIR_BASE[10:8]) begin
          dec.kind = gpio_sc_pkg::KIND_DIR;
          dec.addr = gpio_sc_pkg::ADDR_W'(bank[gpio_sc_pkg::BANK_W-1:0]);
        end else if (offset[10:8] == gpio_sc_pkg::OUT_BASE[10:8]) begin
          dec.kind = gpio_sc_pkg::KIND_OUT;
          dec.addr = gpio_sc_pkg::ADDR_W'(gpio_sc_pkg::BANK_DEPTH)
                   + gpio_sc_pkg::ADDR_W'(bank[gpio_sc_pkg::BANK_W-1:0]);
        end else begin
          dec.kind = gpio_sc_pkg::KIND_IN;
        end
      end else if (offset < gpio_sc_pkg::MODE_END) begin
        dec.kind = gpio_sc_pkg::KIND_MODE;
        dec.mask = gpio_sc_pkg::live_mask(32'(mode_idx) * 8, 8, 4, PIN_COUNT);
        dec.bad = (dec.mask == '0);
        dec.addr = gpio_sc_pkg::ADDR_W'(2 * gpio_sc_pkg::BANK_DEPTH)
                 + gpio_sc_pkg::ADDR_W'(mode_idx);
      end
    end
  end

endmodule
